// ----- rtl/core/s2a_pkg.sv -----
// Package for the signed integer to decimal text unit.
// Holds the widths, character codes and the control struct of the digit cells.
// No dependencies.
package s2a_pkg;

   localparam int ValueWidth     = 32;
   localparam int CharWidth      = 6;
   localparam int NumDigits      = 10;
   localparam int DigitWidth     = 4;
   localparam int RemainWidth    = 4;
   localparam int StepCountWidth = 5;

   localparam logic [StepCountWidth-1:0] LastStep  = 5'd31;
   localparam logic [RemainWidth-1:0]    AllDigits = 4'd10;
   localparam logic [CharWidth-1:0]      CharMinus = 6'd45;
   localparam logic [CharWidth-1:0]      CharZero  = 6'd48;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic move;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/s2a_bcd_cell.sv -----
// One decimal digit cell of the binary to BCD chain.
// Depends on s2a_pkg for the digit width and the cell control struct.
module s2a_bcd_cell
   import s2a_pkg::*;
(
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic                  carry_in,
   input  logic [DigitWidth-1:0] lower_digit,
   output logic                  carry_out,
   output logic [DigitWidth-1:0] digit
);

   logic [DigitWidth-1:0] digit_ff;
   logic [DigitWidth-1:0] digit_in;
   logic [DigitWidth-1:0] adjusted;

   always_comb begin
      adjusted = (digit_ff > 4'd4) ? digit_ff + 4'd3 : digit_ff;
   end

   always_comb begin
      priority if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.dabble) begin
         digit_in = {adjusted[DigitWidth-2:0], carry_in};
      end else if (ctrl.move) begin
         digit_in = lower_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry_out = adjusted[DigitWidth-1];
   assign digit     = digit_ff;

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii_unit.sv -----
// Top level of the signed integer to decimal text unit.
// Depends on s2a_pkg and instantiates a row of s2a_bcd_cell digit cells.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | req_value
//   rsp     | out       | rsp_valid, rsp_stall | rsp_character, rsp_last
//
// A value is loaded, then shifted into the digit cells bit by bit with the add-3 adjust,
// then leading zeros are dropped, one per step, and the characters go out; zeros dropped
// and digits sent always make ten, and a minus sign goes out before the digits.
// Reset is synchronous and clears the control state; the digit cells need none.
// A stalled result beat holds the character register; the next value is taken
// as soon as the last character has been loaded into it.
module signed_int_to_decimal_ascii_unit
   import s2a_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [ValueWidth-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [CharWidth-1:0]        rsp_character,
   output logic                        rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_LEAD,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type                 state_ff;
   logic [StepCountWidth-1:0] step_ff;
   logic [RemainWidth-1:0]    remain_ff;
   logic [ValueWidth-1:0]     mag_ff;
   logic                      neg_ff;
   logic                      rsp_valid_ff;
   logic [CharWidth-1:0]      rsp_character_ff;
   logic                      rsp_last_ff;

   logic [ValueWidth-1:0]     value_bits;
   logic                      out_free;
   logic                      load_char;
   logic [DigitWidth-1:0]     top_digit;
   cell_ctrl_type             cell_ctrl;

   logic [NumDigits-1:0]      carry_row;
   logic [DigitWidth-1:0]     digit_row [NumDigits];

   assign value_bits = req_value;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign load_char  = out_free && ((state_ff == ST_SIGN) || (state_ff == ST_EMIT));
   assign top_digit  = digit_row[NumDigits-1];
   assign req_stall  = (state_ff != ST_IDLE);

   always_comb begin
      cell_ctrl        = '0;
      cell_ctrl.clear  = (state_ff == ST_IDLE) && req_valid;
      cell_ctrl.dabble = (state_ff == ST_CONVERT);
      cell_ctrl.move   = ((state_ff == ST_LEAD) && (top_digit == '0) && (remain_ff != 4'd1))
                      || ((state_ff == ST_EMIT) && out_free);
   end

   for (genvar i = 0; i < NumDigits; i++) begin : g_cell
      if (i == 0) begin : g_first
         s2a_bcd_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl),
            .carry_in    (mag_ff[ValueWidth-1]),
            .lower_digit ('0),
            .carry_out   (carry_row[i]),
            .digit       (digit_row[i])
         );
      end else begin : g_next
         s2a_bcd_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl),
            .carry_in    (carry_row[i-1]),
            .lower_digit (digit_row[i-1]),
            .carry_out   (carry_row[i]),
            .digit       (digit_row[i])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         remain_ff    <= AllDigits;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= load_char;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  neg_ff    <= value_bits[ValueWidth-1];
                  mag_ff    <= value_bits[ValueWidth-1] ? (~value_bits) + 32'd1 : value_bits;
                  step_ff   <= '0;
                  remain_ff <= AllDigits;
                  state_ff  <= ST_CONVERT;
               end
            end
            ST_CONVERT: begin
               mag_ff  <= {mag_ff[ValueWidth-2:0], 1'b0};
               step_ff <= step_ff + 5'd1;
               if (step_ff == LastStep) begin
                  state_ff <= ST_LEAD;
               end
            end
            ST_LEAD: begin
               if ((top_digit == '0) && (remain_ff != 4'd1)) begin
                  remain_ff <= remain_ff - 4'd1;
               end else begin
                  state_ff <= neg_ff ? ST_SIGN : ST_EMIT;
               end
            end
            ST_SIGN: begin
               if (out_free) begin
                  rsp_character_ff <= CharMinus;
                  rsp_last_ff      <= 1'b0;
                  state_ff         <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_character_ff <= CharZero + {2'b00, top_digit};
                  rsp_last_ff      <= (remain_ff == 4'd1);
                  remain_ff        <= remain_ff - 4'd1;
                  if (remain_ff == 4'd1) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_char_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == CharMinus)
                 || ((rsp_character >= CharZero) && (rsp_character <= CharZero + 6'd9)))
      else $error("Result beat carries a character that is neither a digit nor a minus sign.");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_character == CharMinus)) |-> !rsp_last)
      else $error("A minus sign was flagged as the last character.");

   a_convert_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT && step_ff == LastStep) |=> (state_ff == ST_LEAD))
      else $error("Conversion did not end after the final shift step.");

   a_lead_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEAD && top_digit != '0) |=> (state_ff == ST_SIGN || state_ff == ST_EMIT))
      else $error("Leading zero skip passed over a non-zero digit.");
`endif

endmodule

// ----- sim/decimal_text_checker.sv -----
// Checker for the signed integer to decimal text unit: watches both channels,
// predicts the characters of every accepted value and compares each result beat.
// Depends on s2a_pkg for the widths and the character codes.
`timescale 1ns / 1ps

module decimal_text_checker
   import s2a_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [ValueWidth-1:0] req_value,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [CharWidth-1:0]  rsp_character,
   input  logic                  rsp_last,
   output int                    mismatches,
   output int                    chars_pending,
   output int                    values_seen,
   output int                    chars_seen,
   output int                    negatives_seen
);

   localparam int unsigned Radix = 10;

   typedef struct {
      logic [CharWidth-1:0] character;
      logic                 last;
   } char_beat_type;

   char_beat_type expected_chars [$];

   function automatic void queue_decimal_text(input logic [ValueWidth-1:0] value);
      logic [ValueWidth-1:0] magnitude;
      logic [DigitWidth-1:0] digit_list [NumDigits];
      int                    count;
      char_beat_type         beat;
      magnitude = value[ValueWidth-1] ? (~value + 1'b1) : value;
      count     = 0;
      do begin
         digit_list[count] = DigitWidth'(magnitude % Radix);
         magnitude         = magnitude / Radix;
         count++;
      end while (magnitude != 0);
      if (value[ValueWidth-1]) begin
         beat.character = CharMinus;
         beat.last      = 1'b0;
         expected_chars.push_back(beat);
      end
      for (int k = count - 1; k >= 0; k--) begin
         beat.character = CharZero + CharWidth'(digit_list[k]);
         beat.last      = (k == 0);
         expected_chars.push_back(beat);
      end
   endfunction

   always @(posedge clock) begin : watch
      char_beat_type want;
      if (reset) begin
         expected_chars.delete();
         mismatches     = 0;
         chars_pending  = 0;
         values_seen    = 0;
         chars_seen     = 0;
         negatives_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               $error("character: no beat expected, actual %0d", rsp_character);
               mismatches++;
            end else begin
               want = expected_chars.pop_front();
               chars_seen++;
               if (rsp_character !== want.character) begin
                  $error("character: expected %0d, actual %0d", want.character, rsp_character);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            queue_decimal_text(req_value);
            values_seen++;
            if (req_value[ValueWidth-1]) negatives_seen++;
         end
         chars_pending = expected_chars.size();
      end
   end

endmodule

// ----- sim/testbench.sv -----
// Top of the testbench for signed_int_to_decimal_ascii_unit: clock, reset and stimulus.
// Instantiates the block and decimal_text_checker, which predicts and compares.
// Depends on s2a_pkg.
`timescale 1ns / 1ps

module testbench
   import s2a_pkg::*;
();

   localparam int RandomValues = 270;
   localparam int HoldCycles   = 400;
   localparam int IdlePercent  = 17;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [ValueWidth-1:0] req_value;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [CharWidth-1:0]         rsp_character;
   logic                         rsp_last;

   int mismatches;
   int chars_pending;
   int values_seen;
   int chars_seen;
   int negatives_seen;

   bit idle_on;
   bit hold_off_req;

   signed_int_to_decimal_ascii_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   decimal_text_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_character  (rsp_character),
      .rsp_last       (rsp_last),
      .mismatches     (mismatches),
      .chars_pending  (chars_pending),
      .values_seen    (values_seen),
      .chars_seen     (chars_seen),
      .negatives_seen (negatives_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin : receiver
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_done) begin
            hold_left = HoldCycles;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < IdlePercent);
         end
      end
   end

   task automatic send_value(input logic [ValueWidth-1:0] value);
      while (idle_on && ($urandom_range(99) < IdlePercent)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (chars_pending != 0);
   endtask

   function automatic logic [ValueWidth-1:0] random_value();
      longint lo;
      longint hi;
      longint draw;
      longint magnitude;
      int     digits;
      bit     negative;
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom();
         4, 5, 6, 7: begin
            digits   = $urandom_range(1, NumDigits);
            negative = $urandom_range(1);
            lo = 1;
            repeat (digits - 1) lo = lo * 10;
            hi = lo * 10 - 1;
            if (digits == 1) lo = 0;
            if (hi > 64'sd2147483647 + negative) hi = 64'sd2147483647 + negative;
            draw      = {32'd0, $urandom()};
            magnitude = lo + draw % (hi - lo + 1);
            return negative ? ValueWidth'(-magnitude) : ValueWidth'(magnitude);
         end
         default: return ValueWidth'($urandom_range(40)) - ValueWidth'(20);
      endcase
   endfunction

   initial begin : stimulus
      int directed_values [] = '{
         0, 1, -1, 5, -9, 10, -10, 99, 100, -100, 12345, -67890,
         999999999, -999999999, 1000000000, -1000000000, 1999999999,
         2147483647, -2147483647, -2147483647 - 1, -2147483640, 7
      };
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_value    = '0;
      rsp_stall    = 1'b0;
      idle_on      = 1'b1;
      hold_off_req = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_values[i]) send_value(directed_values[i]);

      for (int i = 0; i < RandomValues; i++) begin
         if (i == 60) hold_off_req = 1'b1;
         if (i == 120) drain_results();
         idle_on = !(i >= 150 && i < 210);
         send_value(random_value());
      end
      idle_on = 1'b1;
      drain_results();
      repeat (60) @(negedge clock);

      $display("Summary: %0d values converted into %0d characters, %0d of the values negative.",
               values_seen, chars_seen, negatives_seen);
      $display("Summary: zero, powers of ten and both 32-bit extremes, with stalls on both sides.");
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ----- signed_int_to_decimal_ascii_unit.f -----
rtl/core/s2a_pkg.sv
rtl/core/s2a_bcd_cell.sv
rtl/core/signed_int_to_decimal_ascii_unit.sv
sim/decimal_text_checker.sv
sim/testbench.sv
